// File: rtl/alpd_pkg.sv
// Package for the ASCII length-prefixed deframer: widths, constants and result codes.
`timescale 1ns / 1ps
package alpd_pkg;

  localparam int unsigned HeaderDigits = 4;
  localparam int unsigned DigitCntW    = $clog2(HeaderDigits + 1);
  localparam int unsigned SegW         = 14;
  localparam int unsigned FullW        = SegW + 1;
  localparam int unsigned ProdW        = SegW + 4;
  localparam int unsigned ByteW        = 8;

  localparam logic [SegW-1:0]  SegSizeReset = SegW'(1024);
  localparam logic [SegW-1:0]  AccMax       = {SegW{1'b1}};
  localparam logic [ByteW-1:0] AsciiZero    = 8'h30;
  localparam logic [ByteW-1:0] AsciiNine    = 8'h39;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_DIGIT  = 2'd1,
    ERR_LENGTH = 2'd2
  } err_e;

endpackage

// File: rtl/ascii_length_prefix_deframer.sv
// Top level of the ASCII length-prefixed deframer: header parse, payload count, result register.
//
//  channel    | handshake                  | payload
//  -----------+----------------------------+------------------------------------------
//  rx in      | rx_byte_valid_i / _ready_o | rx_byte_i
//  result out | out_valid_o / out_ready_i  | payload_byte_o, message_end_o, fault_code_o
//  config     | cfg_we_i (no wait)         | cfg_wdata_i (segment_size)
//
// One beat per cycle while the output is not stalled: each byte is parsed in the
// cycle it is accepted and its result, if any, lands in the output register at that edge.
// The header digit step is one multiply-by-ten and add into a saturating
// accumulator; the payload step is one decrement.
// rx_byte_ready_o is high while the output register is empty or being drained.
// Reset puts the block in header hunting with segment_size at 1024.
`timescale 1ns / 1ps
module ascii_length_prefix_deframer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [alpd_pkg::SegW-1:0]  cfg_wdata_i,
  input  logic                       rx_byte_valid_i,
  output logic                       rx_byte_ready_o,
  input  logic [alpd_pkg::ByteW-1:0] rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [alpd_pkg::ByteW-1:0] payload_byte_o,
  output logic                       message_end_o,
  output logic [1:0]                 fault_code_o
);
  import alpd_pkg::*;

  logic [SegW-1:0]      seg_size_q;
  logic                 in_payload_q, in_payload_d;
  logic [DigitCntW-1:0] digits_q, digits_d;
  logic [SegW-1:0]      acc_q, acc_d;
  logic [SegW-1:0]      remain_q, remain_d;
  logic                 final_q, final_d;

  logic                 out_valid_q;
  logic [ByteW-1:0]     out_byte_q, out_byte_d;
  logic                 out_end_q, out_end_d;
  err_e                 out_err_q, out_err_d;
  logic                 emit;

  logic                 in_accept;
  logic                 is_digit;
  logic [ProdW-1:0]     acc_next;
  logic [SegW-1:0]      acc_sat;
  logic [FullW-1:0]     full_len;
  logic [SegW-1:0]      remain_dec;

  assign rx_byte_ready_o = !out_valid_q || out_ready_i;
  assign in_accept       = rx_byte_valid_i && rx_byte_ready_o;

  assign is_digit   = (rx_byte_i >= AsciiZero) && (rx_byte_i <= AsciiNine);
  assign acc_next   = (ProdW'(acc_q) << 3) + (ProdW'(acc_q) << 1)
                    + ProdW'(rx_byte_i - AsciiZero);
  assign acc_sat    = (acc_next > ProdW'(AccMax)) ? AccMax : acc_next[SegW-1:0];
  assign full_len   = FullW'(seg_size_q) + FullW'(1);
  assign remain_dec = (remain_q != '0) ? remain_q - SegW'(1) : remain_q;

  always_comb begin
    in_payload_d = in_payload_q;
    digits_d     = digits_q;
    acc_d        = acc_q;
    remain_d     = remain_q;
    final_d      = final_q;
    emit         = 1'b0;
    out_byte_d   = '0;
    out_end_d    = 1'b0;
    out_err_d    = ERR_NONE;
    if (in_payload_q) begin
      emit       = 1'b1;
      out_byte_d = rx_byte_i;
      remain_d   = remain_dec;
      out_end_d  = (remain_dec == '0) && final_q;
      if (remain_dec == '0) begin
        in_payload_d = 1'b0;
        digits_d     = '0;
        acc_d        = '0;
      end
    end else if (!is_digit) begin
      // drop the byte and hunt for a new header
      emit      = 1'b1;
      out_err_d = ERR_DIGIT;
      digits_d  = '0;
      acc_d     = '0;
    end else if (digits_q != DigitCntW'(HeaderDigits - 1)) begin
      digits_d = digits_q + DigitCntW'(1);
      acc_d    = acc_sat;
    end else begin
      // last header digit: check the length and arm the payload count
      digits_d = '0;
      acc_d    = '0;
      if (acc_sat == '0 || FullW'(acc_sat) > full_len) begin
        emit      = 1'b1;
        out_err_d = ERR_LENGTH;
      end else if (FullW'(acc_sat) == full_len) begin
        final_d      = 1'b0;
        remain_d     = seg_size_q;
        in_payload_d = (seg_size_q != '0);
      end else begin
        final_d      = 1'b1;
        remain_d     = acc_sat;
        in_payload_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_size_q   <= SegSizeReset;
      in_payload_q <= 1'b0;
      digits_q     <= '0;
      acc_q        <= '0;
      remain_q     <= '0;
      final_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seg_size_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        in_payload_q <= in_payload_d;
        digits_q     <= digits_d;
        acc_q        <= acc_d;
        remain_q     <= remain_d;
        final_q      <= final_d;
      end
      if (rx_byte_ready_o) begin
        out_valid_q <= in_accept && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      out_byte_q <= out_byte_d;
      out_end_q  <= out_end_d;
      out_err_q  <= out_err_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = out_byte_q;
  assign message_end_o  = out_end_q;
  assign fault_code_o   = out_err_q;

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_err_q != ERR_NONE |-> out_byte_q == '0 && !out_end_q)
    else $error("error result carries payload data");

  a_digits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digits_q < DigitCntW'(HeaderDigits))
    else $error("header digit count out of range");

  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> remain_q != '0)
    else $error("payload phase with nothing left to count");

  a_last_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_payload_q && remain_q == SegW'(1) && final_q
    |=> out_valid_q && out_end_q && out_err_q == ERR_NONE)
    else $error("last byte of final segment not flagged");

  a_no_mid_header_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !in_payload_q && is_digit && digits_q != DigitCntW'(HeaderDigits - 1)
    |=> !out_valid_q)
    else $error("result produced by a mid-header digit");

endmodule

// File: bench/alpd_checker.sv
// Checker for the ASCII length-prefixed deframer: predicts every result beat and compares it.
`timescale 1ns / 1ps
module alpd_checker
  import alpd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SegW-1:0]  cfg_wdata_i,
  input  logic             rx_byte_valid_i,
  input  logic             rx_byte_ready_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [ByteW-1:0] payload_byte_i,
  input  logic             message_end_i,
  input  logic [1:0]       fault_code_i,
  output int               fail_count_o,
  output int               pending_o,
  output logic             hunting_o
);

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    err_e             err;
  } result_beat_t;

  result_beat_t    expected_beats[$];
  result_beat_t    want_beat;
  result_beat_t    new_beat;

  // Shadow copy of the deframer state and its one register.
  logic [SegW-1:0] seg_size;
  logic            in_payload;
  int              digits_seen;
  int              length_acc;
  int              bytes_left;
  logic            final_seg;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fail_count_o++;
  endtask

  function automatic void clear_header();
    in_payload  = 1'b0;
    digits_seen = 0;
    length_acc  = 0;
  endfunction

  // Advance the shadow state by one received byte; return 1 when a result beat is due.
  function automatic logic deframe_byte(input logic [ByteW-1:0] b, output result_beat_t beat);
    int len;
    int full;
    beat     = '0;
    beat.err = ERR_NONE;
    if (in_payload) begin
      if (bytes_left > 0) bytes_left--;
      beat.data = b;
      beat.last = (bytes_left == 0) && final_seg;
      if (bytes_left == 0) clear_header();
      return 1'b1;
    end
    if (b < AsciiZero || b > AsciiNine) begin
      clear_header();
      beat.err = ERR_DIGIT;
      return 1'b1;
    end
    length_acc = length_acc * 10 + (int'(b) - int'(AsciiZero));
    if (length_acc > int'(AccMax)) length_acc = int'(AccMax);
    digits_seen++;
    if (digits_seen < int'(HeaderDigits)) return 1'b0;
    len  = length_acc;
    full = int'(seg_size) + 1;
    clear_header();
    if (len == 0 || len > full) begin
      beat.err = ERR_LENGTH;
      return 1'b1;
    end
    if (len == full) begin
      final_seg  = 1'b0;
      bytes_left = int'(seg_size);
    end else begin
      final_seg  = 1'b1;
      bytes_left = len;
    end
    // An empty full segment drops straight back to header hunting.
    in_payload = (bytes_left > 0);
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_beats.delete();
      seg_size     = SegSizeReset;
      clear_header();
      bytes_left   = 0;
      final_seg    = 1'b0;
      fail_count_o = 0;
      pending_o   <= 0;
      hunting_o   <= 1'b1;
    end else begin
      // Retire the output beat first: it always belongs to an earlier input.
      if (out_valid_i && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected result beat", int'(fault_code_i), 0);
        end else begin
          want_beat = expected_beats.pop_front();
          if (payload_byte_i !== want_beat.data)
            report_mismatch("payload_byte", int'(payload_byte_i), int'(want_beat.data));
          if (message_end_i !== want_beat.last)
            report_mismatch("message_end", int'(message_end_i), int'(want_beat.last));
          if (fault_code_i !== want_beat.err)
            report_mismatch("fault_code", int'(fault_code_i), int'(want_beat.err));
        end
      end
      if (cfg_we_i) seg_size = cfg_wdata_i;
      if (rx_byte_valid_i && rx_byte_ready_i) begin
        if (deframe_byte(rx_byte_i, new_beat)) expected_beats.push_back(new_beat);
      end
      pending_o <= expected_beats.size();
      hunting_o <= !in_payload && (digits_seen == 0);
    end
  end

endmodule

// File: bench/testbench.sv
// Top of the deframer bench: clock, reset, byte stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps
module testbench;
  import alpd_pkg::*;

  localparam int              IdleLimit   = 2000;
  localparam int              TailCycles  = 8;
  localparam int              RandomItems = 1300;
  localparam int              MaxHeader   = 10 ** HeaderDigits - 1;
  localparam int              MaxSegSize  = 9998;
  localparam logic [ByteW-1:0] FillByte   = 8'h78;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             cfg_we_i        = 1'b0;
  logic [SegW-1:0]  cfg_wdata_i     = '0;
  logic             rx_byte_valid_i = 1'b0;
  logic             rx_byte_ready_o;
  logic [ByteW-1:0] rx_byte_i       = '0;
  logic             out_valid_o;
  logic             out_ready_i     = 1'b0;
  logic [ByteW-1:0] payload_byte_o;
  logic             message_end_o;
  logic [1:0]       fault_code_o;

  int               fail_count;
  int               beats_pending;
  logic             hunting;
  logic             no_idle = 1'b0;
  int               items_sent;
  int               idle_cycles;
  int               seg;
  int               phase;

  ascii_length_prefix_deframer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .rx_byte_valid_i(rx_byte_valid_i),
    .rx_byte_ready_o(rx_byte_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .payload_byte_o (payload_byte_o),
    .message_end_o  (message_end_o),
    .fault_code_o   (fault_code_o)
  );

  alpd_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .rx_byte_valid_i(rx_byte_valid_i),
    .rx_byte_ready_i(rx_byte_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .payload_byte_i (payload_byte_o),
    .message_end_i  (message_end_o),
    .fault_code_i   (fault_code_o),
    .fail_count_o   (fail_count),
    .pending_o      (beats_pending),
    .hunting_o      (hunting)
  );

  always #5 clk_i = ~clk_i;

  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ByteW-1:0] random_non_digit();
    logic [ByteW-1:0] b;
    do b = ByteW'($urandom_range(0, 255)); while (b >= AsciiZero && b <= AsciiNine);
    return b;
  endfunction

  // Leave valid high on return so back-to-back beats never drop it.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      rx_byte_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_byte_valid_i <= 1'b1;
    rx_byte_i       <= b;
    do @(posedge clk_i); while (!rx_byte_ready_o);
    items_sent++;
  endtask

  task automatic send_header(input int len);
    int div;
    div = 10 ** (HeaderDigits - 1);
    repeat (HeaderDigits) begin
      send_byte(AsciiZero + ByteW'((len / div) % 10));
      div = div / 10;
    end
  endtask

  task automatic send_random_bytes(input int n);
    repeat (n) send_byte(ByteW'($urandom_range(0, 255)));
  endtask

  task automatic send_message(input int size);
    int conts;
    int last_len;
    conts = (size <= 64) ? $urandom_range(0, 2) : 0;
    repeat (conts) begin
      send_header(size + 1);
      send_random_bytes(size);
    end
    if (size <= 64 && $urandom_range(0, 4) == 0) last_len = size;
    else last_len = $urandom_range(1, (size < 20) ? size : 20);
    send_header(last_len);
    send_random_bytes(last_len);
  endtask

  task automatic send_noise(input int size);
    case ($urandom_range(0, 2))
      0: send_byte(random_non_digit());
      1: begin
        // Break a header partway through.
        repeat ($urandom_range(0, HeaderDigits - 1))
          send_byte(AsciiZero + ByteW'($urandom_range(0, 9)));
        send_byte(random_non_digit());
      end
      default: begin
        if (size + 2 <= MaxHeader && $urandom_range(0, 1) == 1)
          send_header($urandom_range(size + 2, MaxHeader));
        else
          send_header(0);
      end
    endcase
  endtask

  // Bring the block back to header hunting with nothing in flight, then write the register.
  task automatic write_segment_size(input int value);
    rx_byte_valid_i <= 1'b0;
    @(posedge clk_i);
    while (!hunting) begin
      send_byte(FillByte);
      rx_byte_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    while (beats_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= SegW'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Result side: stall at random, with gap-free stretches.
  initial begin
    int stall;
    @(posedge clk_i);
    forever begin
      stall = idle_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((rx_byte_valid_i && rx_byte_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    items_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats at the reset segment size.
    send_header(3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(AsciiZero);
    send_byte(AsciiZero - 8'd1);
    send_byte(AsciiNine + 8'd1);
    send_byte(AsciiZero + 8'd1);
    send_byte(AsciiZero + 8'd2);
    send_byte(8'hFF);
    send_header(0);
    send_header(MaxHeader);

    // Empty full segment with a zero segment size.
    write_segment_size(0);
    send_header(1);

    items_sent = 0;
    phase      = 0;
    while (items_sent < RandomItems) begin
      case (phase)
        0:       seg = 1;
        1:       seg = MaxSegSize;
        2:       seg = int'(AccMax);
        default: seg = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 24)
                                                      : $urandom_range(25, 200);
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      write_segment_size(seg);
      repeat ($urandom_range(4, 10)) begin
        if ($urandom_range(0, 99) < 80) send_message(seg);
        else send_noise(seg);
      end
      phase++;
    end

    rx_byte_valid_i <= 1'b0;
    @(posedge clk_i);
    while (beats_pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && beats_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
